// ===== sv/mmc_pkg.sv =====
// Shared types and constants of the magnetometer min/max calibration block.
package mmc_pkg;

	localparam int AXES     = 3;
	localparam int SAMPLE_W = 16;
	localparam int OFFSET_W = 17;
	localparam int SCALE_W  = 16;
	localparam int SUM_W    = 18;
	localparam int QUOT_W   = 16;

	localparam logic signed [SAMPLE_W-1:0] MIN_RESET = 16'sd6667;
	localparam logic signed [SAMPLE_W-1:0] MAX_RESET = -16'sd6667;
	localparam logic [SCALE_W-1:0]         SCALE_CAP = 16'hFFFF;

	typedef struct packed {
		logic                           take;
		logic [AXES-1:0][SAMPLE_W-1:0]  mag;
	} queue_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	typedef struct packed {
		logic busy;
		logic sat;
	} div_status_t;

	typedef struct packed {
		logic in_div;
		logic div_busy;
	} back_status_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SPAN,
		BK_START,
		BK_DIV,
		BK_WRITE
	} back_state_t;

endpackage

// ===== sv/mmc_queue.sv =====
// Two-entry queue between the front and the back of the calibration block.
module mmc_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  mmc_pkg::queue_item_t  push_item,
	input  logic                  pop,
	output mmc_pkg::queue_item_t  pop_item,
	output mmc_pkg::queue_status_t status
);
	import mmc_pkg::*;

	queue_item_t entries_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	assign status.full  = (count_q == 2'd2);
	assign status.empty = (count_q == 2'd0);
	assign pop_item     = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ===== sv/mmc_front.sv =====
// Front end: takes input items and marks each one as a tracker update or a skip.
module mmc_front (
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [15:0]     mag_x,
	input  logic signed [15:0]     mag_y,
	input  logic signed [15:0]     mag_z,
	input  logic                   read_ok,
	input  mmc_pkg::queue_status_t q_status,
	output logic                   push,
	output mmc_pkg::queue_item_t   push_item
);
	import mmc_pkg::*;

	logic all_zero;

	assign all_zero          = (mag_x == '0) && (mag_y == '0) && (mag_z == '0);
	assign in_ready          = !q_status.full;
	assign push              = in_valid && in_ready;
	assign push_item.take    = read_ok && !all_zero;
	assign push_item.mag[0]  = mag_x;
	assign push_item.mag[1]  = mag_y;
	assign push_item.mag[2]  = mag_z;

endmodule

// ===== sv/mmc_div.sv =====
// Restoring divider that gives a saturated 16-bit quotient, one bit per cycle.
module mmc_div #(
	parameter int DW = 30
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [DW-1:0]              dividend,
	input  logic [mmc_pkg::SUM_W-1:0]  divisor,
	output mmc_pkg::div_status_t       status,
	output logic [mmc_pkg::QUOT_W-1:0] quotient
);
	import mmc_pkg::*;

	localparam int CW    = (DW > SUM_W + QUOT_W) ? DW : SUM_W + QUOT_W;
	localparam int CNT_W = $clog2(QUOT_W + 1);

	logic             busy_q;
	logic             sat_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] rem_q;
	logic [QUOT_W-1:0] low_q;
	logic [QUOT_W-1:0] quot_q;

	logic             overflow;
	logic [SUM_W:0]   rem_sh;
	logic [SUM_W:0]   rem_diff;
	logic             ge;

	// The quotient only fits in 16 bits when the dividend is below divisor times 2^16.
	assign overflow = (divisor == '0) ||
	                  (CW'(dividend) >= (CW'(divisor) << QUOT_W));
	assign rem_sh   = {rem_q, low_q[QUOT_W-1]};
	assign ge       = (rem_sh >= {1'b0, divisor});
	assign rem_diff = rem_sh - {1'b0, divisor};

	assign status.busy = busy_q;
	assign status.sat  = sat_q;
	assign quotient    = quot_q;

	always_ff @(posedge clk) begin
		if (start) begin
			if (overflow) begin
				sat_q  <= 1'b1;
				quot_q <= SCALE_CAP;
			end else begin
				sat_q  <= 1'b0;
				rem_q  <= SUM_W'(dividend >> QUOT_W);
				low_q  <= dividend[QUOT_W-1:0];
				quot_q <= '0;
			end
		end else if (busy_q) begin
			rem_q  <= ge ? rem_diff[SUM_W-1:0] : rem_sh[SUM_W-1:0];
			low_q  <= low_q << 1;
			quot_q <= {quot_q[QUOT_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= !overflow;
			cnt_q  <= CNT_W'(QUOT_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/mmc_back.sv =====
// Back end: tracks the axis extremes, derives offsets and scales and holds the result.
module mmc_back #(
	parameter int SCALE_FRACTION_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mmc_pkg::queue_status_t q_status,
	input  mmc_pkg::queue_item_t   item,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   accepted,
	output logic signed [16:0]     offset_x,
	output logic signed [16:0]     offset_y,
	output logic signed [16:0]     offset_z,
	output logic [15:0]            scale_x,
	output logic [15:0]            scale_y,
	output logic [15:0]            scale_z,
	output logic                   scale_saturated,
	output mmc_pkg::back_status_t  status
);
	import mmc_pkg::*;

	localparam int DW = SUM_W + SCALE_FRACTION_BITS;
	localparam logic [SCALE_W-1:0] UNITY = (SCALE_FRACTION_BITS >= SCALE_W) ?
		SCALE_CAP : SCALE_W'(1 << SCALE_FRACTION_BITS);

	back_state_t state_q;
	back_state_t state_d;

	logic signed [SAMPLE_W-1:0] min_q [AXES];
	logic signed [SAMPLE_W-1:0] max_q [AXES];
	logic [SAMPLE_W-1:0]        span_q [AXES];
	logic [SUM_W-1:0]           total_q;
	logic signed [OFFSET_W-1:0] held_off_q [AXES];
	logic [SCALE_W-1:0]         held_scale_q [AXES];
	logic                       held_sat_q;
	logic                       out_valid_q;
	logic                       acc_q;

	logic              out_free;
	logic              load_skip;
	logic              track;
	logic              start_div;
	logic              write_held;
	logic [DW-1:0]     dividend;
	logic [SUM_W-1:0]  divisor [AXES];
	div_status_t       div_st [AXES];
	logic [QUOT_W-1:0] quot [AXES];

	assign out_free = !out_valid_q || out_ready;
	assign dividend = DW'(total_q) << SCALE_FRACTION_BITS;

	for (genvar i = 0; i < AXES; i++) begin : g_axis
		assign divisor[i] = {1'b0, span_q[i], 1'b0} + {2'b00, span_q[i]};

		mmc_div #(
			.DW(DW)
		) u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.start    (start_div),
			.dividend (dividend),
			.divisor  (divisor[i]),
			.status   (div_st[i]),
			.quotient (quot[i])
		);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_status.empty && out_free && item.take) begin
					state_d = BK_SPAN;
				end
			end
			BK_SPAN:  state_d = BK_START;
			BK_START: state_d = BK_DIV;
			BK_DIV: begin
				if (!(div_st[0].busy || div_st[1].busy || div_st[2].busy)) begin
					state_d = BK_WRITE;
				end
			end
			BK_WRITE: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop        = 1'b0;
		load_skip  = 1'b0;
		track      = 1'b0;
		start_div  = 1'b0;
		write_held = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				pop       = !q_status.empty && out_free;
				load_skip = pop && !item.take;
				track     = pop && item.take;
			end
			BK_SPAN:  ;
			BK_START: start_div = 1'b1;
			BK_DIV:   ;
			BK_WRITE: write_held = out_free;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
			held_sat_q  <= 1'b0;
			for (int i = 0; i < AXES; i++) begin
				min_q[i]        <= MIN_RESET;
				max_q[i]        <= MAX_RESET;
				held_off_q[i]   <= '0;
				held_scale_q[i] <= UNITY;
			end
		end else begin
			state_q <= state_d;
			if (load_skip || write_held) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (track) begin
				for (int i = 0; i < AXES; i++) begin
					if ($signed(item.mag[i]) < min_q[i]) begin
						min_q[i] <= $signed(item.mag[i]);
					end
					if ($signed(item.mag[i]) > max_q[i]) begin
						max_q[i] <= $signed(item.mag[i]);
					end
				end
			end
			if (write_held) begin
				held_sat_q <= div_st[0].sat || div_st[1].sat || div_st[2].sat;
				for (int i = 0; i < AXES; i++) begin
					held_off_q[i]   <= {max_q[i][SAMPLE_W-1], max_q[i]} +
					                   {min_q[i][SAMPLE_W-1], min_q[i]};
					held_scale_q[i] <= quot[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_skip) begin
			acc_q <= 1'b0;
		end else if (write_held) begin
			acc_q <= 1'b1;
		end
		if (state_q == BK_SPAN) begin
			for (int i = 0; i < AXES; i++) begin
				if (max_q[i] > min_q[i]) begin
					span_q[i] <= SAMPLE_W'(max_q[i] - min_q[i]);
				end else begin
					span_q[i] <= '0;
				end
			end
			total_q <= SUM_W'((max_q[0] > min_q[0]) ?
			                  (SUM_W'(max_q[0]) - SUM_W'(min_q[0])) : '0) +
			           SUM_W'((max_q[1] > min_q[1]) ?
			                  (SUM_W'(max_q[1]) - SUM_W'(min_q[1])) : '0) +
			           SUM_W'((max_q[2] > min_q[2]) ?
			                  (SUM_W'(max_q[2]) - SUM_W'(min_q[2])) : '0);
		end
	end

	assign out_valid       = out_valid_q;
	assign accepted        = acc_q;
	assign offset_x        = held_off_q[0];
	assign offset_y        = held_off_q[1];
	assign offset_z        = held_off_q[2];
	assign scale_x         = held_scale_q[0];
	assign scale_y         = held_scale_q[1];
	assign scale_z         = held_scale_q[2];
	assign scale_saturated = held_sat_q;

	assign status.in_div   = (state_q == BK_DIV);
	assign status.div_busy = div_st[0].busy || div_st[1].busy || div_st[2].busy;

endmodule

// ===== sv/magnetometer_minmax_calibration.sv =====
// Top level of the magnetometer min/max hard-iron and soft-iron calibration block.
// Every input item gives one result item. A skipped sample (failed read or all axes
// zero) leaves a two-entry queue and returns the held results in the next cycle. A
// sample that updates the trackers passes these steps once it leaves the queue: widen
// the extremes, form the spans, load three parallel restoring dividers, run sixteen
// quotient steps, see the dividers finish and write the new offsets and scales. When
// every scale saturates the dividers skip their quotient steps. A result still waiting
// at the output holds back the write until it is taken. The queue lets new items be
// taken while a result waits at the output.
module magnetometer_minmax_calibration #(
	parameter int SCALE_FRACTION_BITS = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] mag_x,
	input  logic signed [15:0] mag_y,
	input  logic signed [15:0] mag_z,
	input  logic               read_ok,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               accepted,
	output logic signed [16:0] offset_x,
	output logic signed [16:0] offset_y,
	output logic signed [16:0] offset_z,
	output logic [15:0]        scale_x,
	output logic [15:0]        scale_y,
	output logic [15:0]        scale_z,
	output logic               scale_saturated
);
	import mmc_pkg::*;

	queue_status_t q_status;
	queue_item_t   push_item;
	queue_item_t   pop_item;
	back_status_t  bk_status;
	logic          push;
	logic          pop;

	mmc_front u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mag_x     (mag_x),
		.mag_y     (mag_y),
		.mag_z     (mag_z),
		.read_ok   (read_ok),
		.q_status  (q_status),
		.push      (push),
		.push_item (push_item)
	);

	mmc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.status    (q_status)
	);

	mmc_back #(
		.SCALE_FRACTION_BITS(SCALE_FRACTION_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_status        (q_status),
		.item            (pop_item),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.accepted        (accepted),
		.offset_x        (offset_x),
		.offset_y        (offset_y),
		.offset_z        (offset_z),
		.scale_x         (scale_x),
		.scale_y         (scale_y),
		.scale_z         (scale_z),
		.scale_saturated (scale_saturated),
		.status          (bk_status)
	);

	// An item taken at the input is held in the queue at the next edge.
	a_accept_queued: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !q_status.empty)
		else $error("accepted item is missing from the queue");

	// The dividers only run while the back end waits for them.
	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		bk_status.div_busy |-> bk_status.in_div)
		else $error("divider busy outside the divide state");

	// Once the dividers are done the back end moves on at once.
	a_div_leave: assert property (@(posedge clk) disable iff (!arst_n)
		bk_status.in_div && !bk_status.div_busy |=> !bk_status.in_div)
		else $error("back end stuck in the divide state");

endmodule

// ===== verif/tb_magnetometer_minmax_calibration.sv =====
// Self-checking testbench for the magnetometer min/max calibration block.
module tb_magnetometer_minmax_calibration;

	import mmc_pkg::*;

	localparam int FRAC = 12;
	localparam logic [15:0] UNITY_SCALE = ((1 << FRAC) > 65535) ? 16'hFFFF : 16'(1 << FRAC);
	localparam int RANDOM_ITEMS = 1960;
	localparam int IDLE_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 64;
	localparam int LONG_HOLD = 500;

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic               ok;
		logic               drain;
	} mag_sample_t;

	typedef struct packed {
		logic             acc;
		logic [2:0][16:0] off;
		logic [2:0][15:0] scl;
		logic             sat;
	} calib_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [15:0] mag_x = '0;
	logic signed [15:0] mag_y = '0;
	logic signed [15:0] mag_z = '0;
	logic               read_ok = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               accepted;
	logic signed [16:0] offset_x;
	logic signed [16:0] offset_y;
	logic signed [16:0] offset_z;
	logic [15:0]        scale_x;
	logic [15:0]        scale_y;
	logic [15:0]        scale_z;
	logic               scale_saturated;

	mag_sample_t sample_backlog[$];
	calib_t      calib_due[$];
	int          faults = 0;
	logic        all_settled = 1'b1;

	int               trk_min[3] = '{MIN_RESET, MIN_RESET, MIN_RESET};
	int               trk_max[3] = '{MAX_RESET, MAX_RESET, MAX_RESET};
	logic [2:0][16:0] held_off = '0;
	logic [2:0][15:0] held_scl = {3{UNITY_SCALE}};
	logic             held_sat = 1'b0;

	int          drv_gap;
	int          drv_sent;
	logic        drv_wait;
	logic        drv_go;
	mag_sample_t drv_item;
	int          snk_taken;
	int          snk_hold;
	logic        long_hold_done;
	calib_t      want;

	magnetometer_minmax_calibration #(.SCALE_FRACTION_BITS(FRAC)) u_top (.*);

	function automatic calib_t track_and_calibrate(logic signed [15:0] sx, logic signed [15:0] sy,
			logic signed [15:0] sz, logic ok);
		int     v[3];
		longint span[3];
		longint total;
		longint q;
		logic   sat;
		calib_t r;
		v[0] = sx;
		v[1] = sy;
		v[2] = sz;
		r.acc = ok && (v[0] != 0 || v[1] != 0 || v[2] != 0);
		if (r.acc) begin
			sat = 1'b0;
			for (int i = 0; i < 3; i++) begin
				if (v[i] < trk_min[i])
					trk_min[i] = v[i];
				if (v[i] > trk_max[i])
					trk_max[i] = v[i];
				held_off[i] = 17'(trk_max[i] + trk_min[i]);
				span[i] = (trk_max[i] > trk_min[i]) ? longint'(trk_max[i] - trk_min[i]) : 0;
			end
			total = span[0] + span[1] + span[2];
			for (int i = 0; i < 3; i++) begin
				if (span[i] == 0) begin
					held_scl[i] = SCALE_CAP;
					sat = 1'b1;
				end else begin
					q = (total << FRAC) / (3 * span[i]);
					if (q > 65535) begin
						held_scl[i] = SCALE_CAP;
						sat = 1'b1;
					end else begin
						held_scl[i] = 16'(q);
					end
				end
			end
			held_sat = sat;
		end
		r.off = held_off;
		r.scl = held_scl;
		r.sat = held_sat;
		return r;
	endfunction

	function automatic int pick_gap(int seq);
		int r;
		if ((seq / 150) % 4 == 1)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic log_fault(string msg);
		faults++;
		if (faults <= 10)
			$display("%s", msg);
	endtask

	task automatic check_field(string name, logic signed [63:0] exp_v, logic signed [63:0] act_v);
		if (exp_v !== act_v)
			log_fault($sformatf("mismatch on %s: expected %0d, got %0d", name, exp_v, act_v));
	endtask

	task automatic add_sample(int x, int y, int z, bit ok, bit drain = 1'b0);
		mag_sample_t s;
		s.x = 16'(x);
		s.y = 16'(y);
		s.z = 16'(z);
		s.ok = ok;
		s.drain = drain;
		sample_backlog.push_back(s);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
	end

	// The sender holds back an item marked for draining until every result is in.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			mag_x <= '0;
			mag_y <= '0;
			mag_z <= '0;
			read_ok <= 1'b0;
			drv_gap = 0;
			drv_sent = 0;
			drv_wait = 1'b0;
		end else if (!in_valid || in_ready) begin
			if (in_valid)
				drv_sent++;
			drv_go = 1'b0;
			if (drv_gap > 0) begin
				drv_gap--;
			end else if (sample_backlog.size() != 0) begin
				if (sample_backlog[0].drain && !drv_wait) begin
					drv_wait = 1'b1;
				end else if (!drv_wait || all_settled) begin
					drv_wait = 1'b0;
					drv_item = sample_backlog.pop_front();
					mag_x <= drv_item.x;
					mag_y <= drv_item.y;
					mag_z <= drv_item.z;
					read_ok <= drv_item.ok;
					drv_go = 1'b1;
					drv_gap = pick_gap(drv_sent);
				end
			end
			in_valid <= drv_go;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			snk_taken = 0;
			snk_hold = 0;
			long_hold_done = 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				snk_taken++;
				snk_hold = pick_gap(snk_taken);
			end
			if (!long_hold_done && snk_taken >= 400) begin
				long_hold_done = 1'b1;
				snk_hold = LONG_HOLD;
			end
			if (snk_hold > 0) begin
				snk_hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				calib_due.push_back(track_and_calibrate(mag_x, mag_y, mag_z, read_ok));
			if (out_valid && out_ready) begin
				if (calib_due.size() == 0) begin
					log_fault("result item arrived with no prediction outstanding");
				end else begin
					want = calib_due.pop_front();
					check_field("accepted", want.acc, accepted);
					check_field("offset_x", $signed(want.off[0]), offset_x);
					check_field("offset_y", $signed(want.off[1]), offset_y);
					check_field("offset_z", $signed(want.off[2]), offset_z);
					check_field("scale_x", want.scl[0], scale_x);
					check_field("scale_y", want.scl[1], scale_y);
					check_field("scale_z", want.scl[2], scale_z);
					check_field("scale_saturated", want.sat, scale_saturated);
				end
			end
			all_settled <= (calib_due.size() == 0);
		end
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if (arst_n && !((in_valid && in_ready) || (out_valid && out_ready)))
				idle++;
			else
				idle = 0;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int centre[3];
		int env[3];
		int v[3];
		int r;
		longint k;
		longint n;

		// Failed reads and all-zero samples must leave the reset results in place.
		add_sample(32767, -32768, -1, 1'b0);
		add_sample(-32768, 32767, 21845, 1'b0);
		add_sample(0, 0, 0, 1'b1);
		add_sample(0, 0, 0, 1'b0);
		add_sample(0, 0, -21846, 1'b0);
		// Samples on the reset bounds leave every span at zero.
		add_sample(6667, -6667, 0, 1'b1);
		// A one-count span on Z drives its scale past the Q4.12 range.
		add_sample(1, 1, 1, 1'b1);
		add_sample(0, 0, 5, 1'b1);
		add_sample(-1, 2, -3, 1'b1);
		add_sample(6666, -6666, 4, 1'b1);
		add_sample(-32768, -32768, -32768, 1'b0);
		add_sample(32767, 32767, 32767, 1'b0);
		add_sample(100, -100, 7, 1'b1);
		add_sample(-6667, 6667, -2, 1'b1);
		add_sample(7000, -7000, 0, 1'b1);

		// The spans grow at different rates per axis so that the scales keep moving.
		for (int a = 0; a < 3; a++)
			centre[a] = int'($urandom_range(0, 4000)) - 2000;
		n = RANDOM_ITEMS;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			k = i;
			r = $urandom_range(0, 99);
			if (r < 8) begin
				add_sample($urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 65535), 1'b0, i == 0);
			end else if (r < 10) begin
				add_sample(0, 0, 0, 1'($urandom_range(0, 1)), i == 0);
			end else begin
				env[0] = 1 + int'(32767 * k / n);
				env[1] = 1 + int'(32767 * k * k / (n * n));
				env[2] = 1 + int'(32767 * k * k * k / (n * n * n));
				for (int a = 0; a < 3; a++) begin
					v[a] = centre[a] + int'($urandom_range(0, 2 * env[a])) - env[a];
					if (v[a] > 32767)
						v[a] = 32767;
					if (v[a] < -32768)
						v[a] = -32768;
				end
				add_sample(v[0], v[1], v[2], 1'b1, i == 0 || i == RANDOM_ITEMS / 2);
			end
		end

		add_sample(32767, 32767, 32767, 1'b1);
		add_sample(-32768, -32768, -32768, 1'b1);
		add_sample(32767, -32768, 0, 1'b1);
		for (int i = 0; i < 8; i++)
			add_sample($urandom_range(0, 65535), $urandom_range(0, 65535),
				$urandom_range(0, 65535), 1'($urandom_range(0, 1)));

		@(posedge clk);
		while (sample_backlog.size() != 0 || in_valid)
			@(posedge clk);
		while (calib_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (faults == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
